>>> hdl/lmpg_pkg.sv
// Shared constants, types and register map of the LCG matrix prefix generator.
// No dependencies; imported by every module of the block.
package lmpg_pkg;

  localparam int VALUE_BITS = 15;
  localparam int PROD_W     = 2 * VALUE_BITS;
  // remainder unit retires two dividend bits per cycle
  localparam int RED_STEPS  = PROD_W / 2;
  localparam int RED_CNT_W  = $clog2(RED_STEPS);

  localparam int NUM_REGS   = 6;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int ADDR_W     = REG_IDX_W + 2;
  localparam int DATA_W     = 32;

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_STEP = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef struct packed {
    logic vld;
    op_t  op;
  } op_req_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MULTIPLIER    = 3'd0,
    REG_INCREMENT     = 3'd1,
    REG_MODULUS       = 3'd2,
    REG_START_VALUE   = 3'd3,
    REG_PREFIX_SCALE  = 3'd4,
    REG_PREFIX_OFFSET = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] multiplier;
    logic [VALUE_BITS-1:0] increment;
    logic [VALUE_BITS-1:0] modulus;
    logic [VALUE_BITS-1:0] start_value;
    logic [VALUE_BITS-1:0] prefix_scale;
    logic [VALUE_BITS-1:0] prefix_offset;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    multiplier:    VALUE_BITS'(1),
    increment:     VALUE_BITS'(0),
    modulus:       VALUE_BITS'(32767),
    start_value:   VALUE_BITS'(0),
    prefix_scale:  VALUE_BITS'(1),
    prefix_offset: VALUE_BITS'(0)
  };

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RUN,
    BK_PFX_GO,
    BK_PFX,
    BK_VAL
  } bk_state_t;

endpackage

>>> hdl/lcg_matrix_prefix_generator_unit.sv
// Top level of the LCG matrix prefix generator: register file, front end,
// op queue and back end. Depends on lmpg_pkg, lmpg_front, lmpg_queue, lmpg_back.
// Pacing: the back end handles one request at a time, at a pace set by the
//   remainder units, each retiring two dividend bits per cycle.
// Reset (synchronous, rst_n low): registers return to their defaults, the
//   running product to identity, the queue and result register empty.
module lcg_matrix_prefix_generator_unit import lmpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_restart,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_value,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  cfg_t                  cfg_r, cfg_nxt;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic [VALUE_BITS-1:0] wr_val;
  logic [VALUE_BITS-1:0] rd_val;

  op_req_t push;
  op_req_t head;
  logic    q_full;
  logic    pop;

  // ---------------------------------------------------------------------
  // Register file. Writes complete in the access phase; pready is tied high.
  // Data above VALUE_BITS is dropped, unmapped indexes are ignored.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_val  = pwdata[VALUE_BITS-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    rd_val  = '0;
    unique case (reg_idx)
      REG_MULTIPLIER: begin
        rd_val = cfg_r.multiplier;
        if (wr_en) cfg_nxt.multiplier = wr_val;
      end
      REG_INCREMENT: begin
        rd_val = cfg_r.increment;
        if (wr_en) cfg_nxt.increment = wr_val;
      end
      REG_MODULUS: begin
        rd_val = cfg_r.modulus;
        if (wr_en) cfg_nxt.modulus = wr_val;
      end
      REG_START_VALUE: begin
        rd_val = cfg_r.start_value;
        if (wr_en) cfg_nxt.start_value = wr_val;
      end
      REG_PREFIX_SCALE: begin
        rd_val = cfg_r.prefix_scale;
        if (wr_en) cfg_nxt.prefix_scale = wr_val;
      end
      REG_PREFIX_OFFSET: begin
        rd_val = cfg_r.prefix_offset;
        if (wr_en) cfg_nxt.prefix_offset = wr_val;
      end
      default: rd_val = '0;
    endcase
  end

  assign prdata = DATA_W'(rd_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Front end: accepts requests, tags them load (restart or first after
  // reset) or step, and pushes them into the queue. Stalls when full.
  // ---------------------------------------------------------------------
  lmpg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_stall   (in_stall),
    .q_full     (q_full),
    .push       (push)
  );

  // Two-entry queue lets the front keep taking requests while the back
  // end is busy or the result register is held by a stalled consumer.
  lmpg_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  // ---------------------------------------------------------------------
  // Back end: step (running*base), prefix (running*prefix) and the final
  // seed application, each a multiply-add followed by an iterative mod.
  // ---------------------------------------------------------------------
  lmpg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value)
  );

endmodule

>>> hdl/lmpg_front.sv
// Front end: takes input requests and classifies them as load or step.
// Depends on lmpg_pkg.
module lmpg_front import lmpg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_restart,
  output logic    in_stall,
  input  logic    q_full,
  output op_req_t push
);

  logic started_r;
  logic started_nxt;
  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // the very first step after reset behaves like a restart
  always_comb begin
    push.vld    = accept;
    push.op     = (in_restart || !started_r) ? OP_LOAD : OP_STEP;
    started_nxt = started_r || accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
    end
  end

endmodule

>>> hdl/lmpg_queue.sv
// Short op queue between front end and back end.
// Depends on lmpg_pkg.
module lmpg_queue import lmpg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  op_req_t push,
  input  logic    pop,
  output op_req_t head,
  output logic    full
);

  op_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    if (p == QPTR_W'(QDEPTH - 1)) n = '0;
    else                          n = p + QPTR_W'(1);
    return n;
  endfunction

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign head.vld = (count_r != '0);
  assign head.op  = mem_r[rd_ptr_r];

  always_comb begin
    do_push    = push.vld && !full;
    do_pop     = pop && head.vld;
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + QCNT_W'(1);
    if (do_pop && !do_push) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.op;
    end
  end

endmodule

>>> hdl/lmpg_modred.sv
// Iterative remainder unit: x mod m, two dividend bits per cycle.
// Depends on lmpg_pkg. A modulus below two yields zero.
module lmpg_modred import lmpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [PROD_W-1:0]     x,
  input  logic [VALUE_BITS-1:0] modulus,
  output logic                  busy,
  output logic [VALUE_BITS-1:0] result
);

  logic [PROD_W-1:0]     x_r, x_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [RED_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic [VALUE_BITS-1:0] rem_a, rem_b;

  // one restoring step; rem < m keeps the shifted value below 2m
  function automatic logic [VALUE_BITS-1:0] rem_step(
    input logic [VALUE_BITS-1:0] rem,
    input logic                  b,
    input logic [VALUE_BITS-1:0] m
  );
    logic [VALUE_BITS:0] t;
    t = {rem, b};
    if (t >= {1'b0, m}) t = t - {1'b0, m};
    return t[VALUE_BITS-1:0];
  endfunction

  assign rem_a  = rem_step(rem_r, x_r[PROD_W-1], modulus);
  assign rem_b  = rem_step(rem_a, x_r[PROD_W-2], modulus);
  assign busy   = busy_r;
  assign result = (modulus < VALUE_BITS'(2)) ? '0 : rem_r;

  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      x_nxt    = x;
      rem_nxt  = '0;
      cnt_nxt  = RED_CNT_W'(RED_STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt    = {x_r[PROD_W-3:0], 2'b00};
      rem_nxt  = rem_b;
      cnt_nxt  = cnt_r - RED_CNT_W'(1);
      busy_nxt = (cnt_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
  end

endmodule

>>> hdl/lmpg_back.sv
// Back end: sequences the matrix products over two remainder units and
// holds the result register. Depends on lmpg_pkg and lmpg_modred.
module lmpg_back import lmpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  op_req_t               head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_value
);

  bk_state_t             state_r, state_nxt;
  logic [VALUE_BITS-1:0] rs_r, rs_nxt;   // running scale
  logic [VALUE_BITS-1:0] ro_r, ro_nxt;   // running offset
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;

  logic                  start0, start1;
  logic [VALUE_BITS-1:0] a0, b0, c0, a1, b1, c1;
  logic [PROD_W-1:0]     x0, x1;
  logic                  busy0, busy1;
  logic [VALUE_BITS-1:0] res0, res1;
  logic                  out_free;
  logic                  red_idle;

  assign x0 = PROD_W'(a0) * PROD_W'(b0) + PROD_W'(c0);
  assign x1 = PROD_W'(a1) * PROD_W'(b1) + PROD_W'(c1);

  lmpg_modred u_red0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start0),
    .x       (x0),
    .modulus (cfg.modulus),
    .busy    (busy0),
    .result  (res0)
  );

  lmpg_modred u_red1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start1),
    .x       (x1),
    .modulus (cfg.modulus),
    .busy    (busy1),
    .result  (res1)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign red_idle  = !busy0 && !busy1;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  always_comb begin
    state_nxt     = state_r;
    rs_nxt        = rs_r;
    ro_nxt        = ro_r;
    pop           = 1'b0;
    start0        = 1'b0;
    start1        = 1'b0;
    a0 = '0; b0 = '0; c0 = '0;
    a1 = '0; b1 = '0; c1 = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;

    unique case (state_r)
      BK_IDLE: begin
        if (head.vld) begin
          pop = 1'b1;
          if (head.op == OP_LOAD) begin
            // entries taken unreduced; later products reduce them
            rs_nxt    = cfg.multiplier;
            ro_nxt    = cfg.increment;
            state_nxt = BK_PFX_GO;
          end else begin
            // running * base: [A*a, B*a+b]
            start0 = 1'b1;
            start1 = 1'b1;
            a0 = rs_r; b0 = cfg.multiplier;
            a1 = ro_r; b1 = cfg.multiplier; c1 = cfg.increment;
            state_nxt = BK_RUN;
          end
        end
      end
      BK_RUN: begin
        if (red_idle) begin
          rs_nxt    = res0;
          ro_nxt    = res1;
          state_nxt = BK_PFX_GO;
        end
      end
      BK_PFX_GO: begin
        // running * prefix
        start0 = 1'b1;
        start1 = 1'b1;
        a0 = rs_r; b0 = cfg.prefix_scale;
        a1 = ro_r; b1 = cfg.prefix_scale; c1 = cfg.prefix_offset;
        state_nxt = BK_PFX;
      end
      BK_PFX: begin
        if (red_idle) begin
          // (seed, 1) applied to the product
          start0 = 1'b1;
          a0 = cfg.start_value; b0 = res0; c0 = res1;
          state_nxt = BK_VAL;
        end
      end
      BK_VAL: begin
        if (red_idle && out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res0;
          state_nxt     = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      rs_r        <= VALUE_BITS'(1);
      ro_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rs_r        <= rs_nxt;
      ro_r        <= ro_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
  end

endmodule

>>> hdl/lmpg_checker.sv
// Port-level checker for the LCG matrix prefix generator, bound to the top.
// Depends on lmpg_pkg and lcg_matrix_prefix_generator_unit.
module lmpg_checker import lmpg_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [VALUE_BITS-1:0] out_value,
  input logic                  pready
);

  // held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value))
    else $error("result changed or dropped while stalled");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // reset empties the queue, so requests are taken at once
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // a result cannot appear the cycle right after an idle reset
  a_no_early: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> !out_valid)
    else $error("result without a request");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind lcg_matrix_prefix_generator_unit lmpg_checker u_lmpg_checker (.*);
